[src/mvt_pkg.sv]
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared constants and types for the minimum version tracker and its cells.
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int NUM_SERVERS = 16;
	localparam int VER_W       = 32;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 2;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(2);

	localparam logic OP_SET     = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// values held steady for the whole pass along the chain
	typedef struct packed {
		logic [VER_W-1:0] ver;
		logic [VER_W-1:0] cur_min;
		logic [VER_W-1:0] bound;
		logic             plain;
	} cell_bcast_t;

	// token handed from one cell to the next
	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] cnt;
		logic [VER_W-1:0] best;
		logic             sel_eq_ver;
		logic             sel_eq_min;
	} cell_link_t;

endpackage

[src/mvt_cell.sv]
// ----------------------------------------------------------------------------
// mvt_cell
// One server entry: counts minimum holders and ranks its value on the token.
// ----------------------------------------------------------------------------
module mvt_cell
	import mvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cell_bcast_t bc,
	input  logic        sel,
	input  logic        wr,
	input  cell_link_t  link_in,
	output cell_link_t  link_out
);

	logic [VER_W-1:0] entry_q;
	cell_link_t       link_q;
	cell_link_t       link_d;
	logic [VER_W-1:0] cand;
	logic             cand_hi;
	logic             best_hi;
	logic             cand_lt;
	logic             better;

	// the selected entry already takes its new value in the ranking
	assign cand    = sel ? bc.ver : entry_q;
	assign cand_hi = cand > bc.bound;
	assign best_hi = link_in.best > bc.bound;
	assign cand_lt = cand < link_in.best;

	always_comb begin
		if (bc.plain) begin
			better = cand_lt;
		end else if (cand_hi != best_hi) begin
			better = cand_hi;
		end else begin
			better = cand_lt;
		end
	end

	always_comb begin
		link_d = link_in;
		if (entry_q == bc.cur_min && link_in.cnt != CNT_SAT) begin
			link_d.cnt = link_in.cnt + CNT_ONE;
		end
		if (better) begin
			link_d.best = cand;
		end
		if (sel) begin
			link_d.sel_eq_ver = (entry_q == bc.ver);
			link_d.sel_eq_min = (entry_q == bc.cur_min);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '1;
			link_q  <= '0;
		end else begin
			link_q <= link_d;
			if (wr && sel) begin
				entry_q <= bc.ver;
			end
		end
	end

	assign link_out = link_q;

endmodule

[src/min_version_tracker_unit.sv]
// ----------------------------------------------------------------------------
// min_version_tracker_unit
// Per-server version table with running minimum and a wrapping upper bound.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis: tuser is the op (0 set, 1 advance), tdata
// carries the server index and the new version. Every input beat yields one
// output beat on m_axis with the change flag, the minimum and the bound.
// A set beat runs one token down a row of NUM_SERVERS cells, one cell per
// cycle; the token counts holders of the old minimum and ranks every entry
// (new value included). An advance skips the row and goes straight to the
// result. One beat is in flight at a time; s_axis_tready is high only while
// the unit is idle, so a new beat is taken only after the result is
// registered. The result sits in an output register, and if that register
// still holds a beat that m_axis_tready has not taken, the unit holds the
// finished item and commits it once the output register frees up.
// Reset sets every entry, the minimum and the bound to all ones and leaves
// the unit idle with no output pending.
// ----------------------------------------------------------------------------
module min_version_tracker_unit
	import mvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // server_index[3:0], new_version[35:4], zero pad
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // min_changed[0], minimum[32:1],
	                                   // upper_bound[64:33], zero pad
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic             start_q;
	logic             op_q;
	logic [IDX_W-1:0] idx_q;
	logic [VER_W-1:0] ver_q;
	logic             plain_q;
	logic [VER_W-1:0] cur_min_q;
	logic [VER_W-1:0] bound_q;
	cell_link_t       fin_q;
	logic             out_valid_q;
	logic             out_changed_q;
	logic [VER_W-1:0] out_min_q;
	logic [VER_W-1:0] out_bound_q;

	cell_bcast_t      bc;
	cell_link_t       links [NUM_SERVERS+1];
	logic             in_fire;
	logic             out_free;
	logic             out_load;
	logic             idx_ok;
	logic             sole;
	logic             wr_en;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_DONE) && out_free;
	assign idx_ok        = 32'(idx_q) < 32'(NUM_SERVERS);
	assign sole          = fin_q.sel_eq_min && (fin_q.cnt == CNT_ONE);
	assign wr_en         = out_load && (op_q == OP_SET) && idx_ok && !fin_q.sel_eq_ver;

	assign bc.ver     = ver_q;
	assign bc.cur_min = cur_min_q;
	assign bc.bound   = bound_q;
	assign bc.plain   = plain_q;

	assign links[0].valid      = start_q;
	assign links[0].cnt        = '0;
	assign links[0].best       = ver_q;
	assign links[0].sel_eq_ver = 1'b0;
	assign links[0].sel_eq_min = 1'b0;

	for (genvar i = 0; i < NUM_SERVERS; i++) begin : g_cell
		mvt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bc       (bc),
			.sel      (32'(idx_q) == i),
			.wr       (wr_en),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			start_q       <= 1'b0;
			cur_min_q     <= '1;
			bound_q       <= '1;
			out_valid_q   <= 1'b0;
			out_changed_q <= 1'b0;
			out_min_q     <= '0;
			out_bound_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser == OP_ADVANCE) begin
							state_q <= ST_DONE;
						end else begin
							start_q <= 1'b1;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					start_q <= 1'b0;
					if (links[NUM_SERVERS].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (op_q == OP_ADVANCE) begin
							bound_q       <= bound_q + VER_W'(1);
							out_changed_q <= 1'b0;
							out_min_q     <= cur_min_q;
							out_bound_q   <= bound_q + VER_W'(1);
						end else begin
							out_changed_q <= wr_en && sole;
							out_min_q     <= (wr_en && sole) ? fin_q.best : cur_min_q;
							out_bound_q   <= bound_q;
							if (wr_en && sole) begin
								cur_min_q <= fin_q.best;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= s_axis_tuser;
			idx_q   <= s_axis_tdata[IDX_W-1:0];
			ver_q   <= s_axis_tdata[IDX_W +: VER_W];
			plain_q <= cur_min_q < bound_q;
		end
		if (state_q == ST_RUN && links[NUM_SERVERS].valid) begin
			fin_q <= links[NUM_SERVERS];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_bound_q, out_min_q, out_changed_q};

endmodule
